[rtl/core/mwlfo_pkg.sv]
// ----------------------------------------------------------------------------
// mwlfo_pkg
// Shared types, widths, register codes and the quarter-wave sine table
// ----------------------------------------------------------------------------
package mwlfo_pkg;

    localparam int CHANNELS        = 2;
    localparam int SINE_TABLE_BITS = 10;

    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
    localparam int ROM_ADDR_W  = SINE_TABLE_BITS - 1;

    // field widths
    localparam int PHASE_W = 32;
    localparam int FIELD_W = 16;
    localparam int VALUE_W = 18;
    localparam int WAVE_W  = 17;
    localparam int PPH_W   = 28;
    localparam int CFG_W   = 28;
    localparam int CFG_IDX_W = 2;
    localparam int MAC_A_W = 18;
    localparam int MAC_B_W = 29;
    localparam int MAC_P_W = MAC_A_W + MAC_B_W;
    localparam int ACC_W   = MAC_P_W + 1;

    localparam logic signed [WAVE_W-1:0] FULL_SCALE     = 17'sd32768;
    localparam logic signed [WAVE_W-1:0] NEG_FULL_SCALE = -17'sd32768;
    localparam logic [15:0]              MIX_FULL       = 16'd32768;
    localparam logic [PHASE_W-1:0]       QUARTER_TURN   = 32'h4000_0000;

    // waveform codes
    typedef logic [2:0] t_waveform;
    localparam t_waveform WAVE_SINE      = 3'd0;
    localparam t_waveform WAVE_COSINE    = 3'd1;
    localparam t_waveform WAVE_SQUARE    = 3'd2;
    localparam t_waveform WAVE_TRIANGLE  = 3'd3;
    localparam t_waveform WAVE_CROSSFADE = 3'd4;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WAVEFORM     = 2'd0;
    localparam t_cfg_idx CFG_PHASE_PER_HZ = 2'd1;
    localparam t_cfg_idx CFG_MIX          = 2'd2;

    localparam t_waveform           WAVEFORM_RST     = WAVE_SINE;
    localparam logic [PPH_W-1:0]    PHASE_PER_HZ_RST = 28'd22906492;
    localparam logic [15:0]         MIX_RST          = 16'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SELECT,
        ST_MIX,
        ST_FADE,
        ST_SCALE,
        ST_STEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic en;
        logic accumulate;
    } t_mac_ctrl;

    // quarter-wave table, built at elaboration from a q30 odd polynomial
    localparam longint Q30       = 64'sd1 <<< 30;
    localparam longint ROM_SCALE = 64'sd32768;
    localparam longint ROM_HALF  = 64'sd16384;
    localparam longint SIN_POLY [0:6] = '{
        64'sd61, -64'sd3864, 64'sd172272, -64'sd5026995,
        64'sd85569306, -64'sd693598668, 64'sd1686629713
    };

    typedef logic [QUARTER_LEN:0][15:0] t_sine_rom;

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint    u;
        longint    u2;
        longint    acc;
        longint    s;
        rom = '0;
        for (int r = 0; r <= QUARTER_LEN; r++) begin
            u   = longint'(r) <<< (32 - SINE_TABLE_BITS);
            u2  = (u * u) / Q30;
            acc = SIN_POLY[0];
            for (int k = 1; k < 7; k++) begin
                acc = SIN_POLY[k] + (acc * u2) / Q30;
            end
            s = (acc * u) / Q30;
            if (s < 0) begin
                s = 0;
            end
            s = (s + ROM_HALF) / ROM_SCALE;
            if (s > ROM_SCALE) begin
                s = ROM_SCALE;
            end
            rom[r] = s[15:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

[rtl/core/mwlfo_in_if.sv]
// ----------------------------------------------------------------------------
// mwlfo_in_if
// Input item channel: channel select, rate, depth, centre and phase offset
// ----------------------------------------------------------------------------
interface mwlfo_in_if
    import mwlfo_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [0:0]         channel;
    logic [FIELD_W-1:0] rate;
    logic [FIELD_W-1:0] depth;
    logic [FIELD_W-1:0] centre;
    logic [FIELD_W-1:0] phase_offset;

    modport source (
        output valid, channel, rate, depth, centre, phase_offset,
        input  ready
    );

    modport sink (
        input  valid, channel, rate, depth, centre, phase_offset,
        output ready
    );
endinterface

[rtl/core/mwlfo_out_if.sv]
// ----------------------------------------------------------------------------
// mwlfo_out_if
// Result item channel: signed oscillator value
// ----------------------------------------------------------------------------
interface mwlfo_out_if
    import mwlfo_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (
        output valid, value,
        input  ready
    );

    modport sink (
        input  valid, value,
        output ready
    );
endinterface

[rtl/core/mwlfo_wave.sv]
// ----------------------------------------------------------------------------
// mwlfo_wave
// Registered sine table lookup and triangle shaping from a phase word
// ----------------------------------------------------------------------------
module mwlfo_wave
    import mwlfo_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [PHASE_W-1:0]        i_phase,
    input  t_waveform                 i_waveform,
    input  logic [FIELD_W-1:0]        i_phase_offset,
    output logic signed [WAVE_W-1:0]  o_sine,
    output logic signed [WAVE_W-1:0]  o_tri
);

    logic [PHASE_W-1:0]          ph_sel;
    logic [SINE_TABLE_BITS-1:0]  idx;
    logic [ROM_ADDR_W-1:0]       low;
    logic [ROM_ADDR_W-1:0]       addr;
    logic [15:0]                 mag;
    logic signed [WAVE_W-1:0]    sine_mag;
    logic signed [WAVE_W-1:0]    n_sine;
    logic signed [WAVE_W-1:0]    tri_frac;
    logic signed [WAVE_W-1:0]    tri_mag;
    logic signed [WAVE_W-1:0]    n_tri;
    logic signed [WAVE_W-1:0]    r_sine;
    logic signed [WAVE_W-1:0]    r_tri;

    always_comb begin
        case (i_waveform)
            WAVE_COSINE: begin
                ph_sel = i_phase + QUARTER_TURN;
            end
            WAVE_SQUARE, WAVE_TRIANGLE, WAVE_CROSSFADE: begin
                ph_sel = i_phase;
            end
            default: begin
                // sine and the unused codes take the phase offset
                ph_sel = i_phase + {i_phase_offset, 16'd0};
            end
        endcase
    end

    // mirror the quarter table in odd quadrants, negate in the lower half
    assign idx  = ph_sel[PHASE_W-1 -: SINE_TABLE_BITS];
    assign low  = {1'b0, idx[SINE_TABLE_BITS-3:0]};
    assign addr = idx[SINE_TABLE_BITS-2] ? (ROM_ADDR_W'(QUARTER_LEN) - low) : low;
    assign mag  = SINE_ROM[addr];
    assign sine_mag = signed'({1'b0, mag});
    assign n_sine   = idx[SINE_TABLE_BITS-1] ? -sine_mag : sine_mag;

    assign tri_frac = signed'({2'b00, i_phase[29:15]});
    assign tri_mag  = i_phase[30] ? (FULL_SCALE - tri_frac) : tri_frac;
    assign n_tri    = i_phase[31] ? -tri_mag : tri_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sine <= n_sine;
            r_tri  <= n_tri;
        end
    end

    assign o_sine = r_sine;
    assign o_tri  = r_tri;

endmodule

[rtl/core/mwlfo_mac.sv]
// ----------------------------------------------------------------------------
// mwlfo_mac
// Shared signed multiply-accumulate unit with a registered accumulator
// ----------------------------------------------------------------------------
module mwlfo_mac
    import mwlfo_pkg::*;
(
    input  logic                       i_clk,
    input  t_mac_ctrl                  i_ctrl,
    input  logic signed [MAC_A_W-1:0]  i_a,
    input  logic signed [MAC_B_W-1:0]  i_b,
    output logic signed [ACC_W-1:0]    o_acc
);

    logic signed [MAC_P_W-1:0] prod;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   r_acc;

    assign prod  = i_a * i_b;
    assign n_acc = i_ctrl.accumulate ? (r_acc + ACC_W'(prod)) : ACC_W'(prod);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

[rtl/core/multi_waveform_lfo_top.sv]
// ----------------------------------------------------------------------------
// multi_waveform_lfo_top
// Per-channel phase accumulator oscillator: sine, cosine, square, triangle
// and sine-to-triangle crossfade, scaled by depth and offset by centre
// ----------------------------------------------------------------------------
// An item is taken in the idle state and its result follows from an output
// register, so a new item can be taken while the last result waits. Without
// crossfade an item runs through lookup, select, scale, step and done, and the
// idle state then takes the next item; crossfade adds the mix and fade steps.
// The sequence is set by the single shared multiply-accumulate unit, which
// does the depth scaling and the phase step, plus two weighted terms for the
// crossfade. The done state waits while the output register is still full.
// Phase accumulators reset to zero and wrap modulo one full turn.
module multi_waveform_lfo_top
    import mwlfo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    mwlfo_in_if.sink              i_in,
    mwlfo_out_if.source           o_out
);

    t_state r_state;
    t_state n_state;

    t_waveform          r_waveform;
    logic [PPH_W-1:0]   r_phase_per_hz;
    logic [15:0]        r_mix;

    logic [CHANNELS-1:0][PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0]               r_ph_cur;

    logic [CH_IDX_W-1:0] in_idx;
    logic [CH_IDX_W-1:0] r_idx;
    logic [FIELD_W-1:0]  r_rate;
    logic [FIELD_W-1:0]  r_depth;
    logic [FIELD_W-1:0]  r_centre;
    logic [FIELD_W-1:0]  r_poff;

    logic signed [WAVE_W-1:0]  sine;
    logic signed [WAVE_W-1:0]  tri_w;
    logic signed [WAVE_W-1:0]  r_wave;
    logic signed [WAVE_W-1:0]  n_wave;
    logic                      wave_load;
    logic                      wave_en;

    logic [15:0]               mix_sat;
    t_mac_ctrl                 mac_ctrl;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   fade_sum;

    logic [32:0]               scale_sum;
    logic [VALUE_W-1:0]        n_value;
    logic [VALUE_W-1:0]        r_value;
    logic                      value_load;

    logic                      in_fire;
    logic                      out_free;
    logic                      finish;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform     <= WAVEFORM_RST;
            r_phase_per_hz <= PHASE_PER_HZ_RST;
            r_mix          <= MIX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAVEFORM:     r_waveform     <= i_cfg_data[2:0];
                CFG_PHASE_PER_HZ: r_phase_per_hz <= i_cfg_data[PPH_W-1:0];
                CFG_MIX:          r_mix          <= i_cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_idx     = (CHANNELS == 1) ? '0 : CH_IDX_W'(i_in.channel);
    assign out_free   = !r_out_valid || o_out.ready;
    assign finish     = (r_state == ST_DONE) && out_free;
    assign mix_sat    = (r_mix > MIX_FULL) ? MIX_FULL : r_mix;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_idx    <= in_idx;
            r_rate   <= i_in.rate;
            r_depth  <= i_in.depth;
            r_centre <= i_in.centre;
            r_poff   <= i_in.phase_offset;
            r_ph_cur <= r_phase[in_idx];
        end
    end

    mwlfo_wave u_wave (
        .i_clk          (i_clk),
        .i_en           (wave_en),
        .i_phase        (r_ph_cur),
        .i_waveform     (r_waveform),
        .i_phase_offset (r_poff),
        .o_sine         (sine),
        .o_tri          (tri_w)
    );

    mwlfo_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_acc  (acc)
    );

    // floor((w + 16384) / 32768) of the weighted sum
    assign fade_sum  = (acc + ACC_W'(16384)) >>> 15;
    assign scale_sum = acc[32:0] + 33'd16384;
    assign n_value   = VALUE_W'(r_centre) + scale_sum[32:15] - VALUE_W'(r_depth);

    // sequencer
    always_comb begin
        n_state    = r_state;
        wave_en    = 1'b0;
        wave_load  = 1'b0;
        n_wave     = sine;
        value_load = 1'b0;
        mac_ctrl   = '0;
        mac_a      = '0;
        mac_b      = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                wave_en = 1'b1;
                n_state = ST_SELECT;
            end
            ST_SELECT: begin
                if (r_waveform == WAVE_CROSSFADE) begin
                    mac_ctrl.en = 1'b1;
                    mac_a       = MAC_A_W'(sine);
                    mac_b       = signed'(MAC_B_W'(MIX_FULL - mix_sat));
                    n_state     = ST_MIX;
                end else begin
                    wave_load = 1'b1;
                    case (r_waveform)
                        WAVE_SQUARE: begin
                            // a table zero counts as non-negative
                            n_wave = (sine >= 0) ? NEG_FULL_SCALE : FULL_SCALE;
                        end
                        WAVE_TRIANGLE: begin
                            n_wave = tri_w;
                        end
                        default: begin
                            n_wave = sine;
                        end
                    endcase
                    n_state = ST_SCALE;
                end
            end
            ST_MIX: begin
                mac_ctrl.en         = 1'b1;
                mac_ctrl.accumulate = 1'b1;
                mac_a               = MAC_A_W'(tri_w);
                mac_b               = signed'(MAC_B_W'(mix_sat));
                n_state             = ST_FADE;
            end
            ST_FADE: begin
                wave_load = 1'b1;
                n_wave    = fade_sum[WAVE_W-1:0];
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                mac_ctrl.en = 1'b1;
                mac_a       = MAC_A_W'(r_wave) + MAC_A_W'(FULL_SCALE);
                mac_b       = signed'(MAC_B_W'(r_depth));
                n_state     = ST_STEP;
            end
            ST_STEP: begin
                value_load  = 1'b1;
                mac_ctrl.en = 1'b1;
                mac_a       = signed'(MAC_A_W'(r_rate));
                mac_b       = signed'(MAC_B_W'(r_phase_per_hz));
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wave_load) begin
            r_wave <= n_wave;
        end
        if (value_load) begin
            r_value <= n_value;
        end
    end

    // phase advance by (rate * phase_per_hz) >> 16, held in the accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (finish) begin
            r_phase[r_idx] <= r_ph_cur + acc[PHASE_W+15:16];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_value <= signed'(r_value);
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_LOOKUP))
        else $error("accepted item did not start the lookup");

    a_wave_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCALE) |-> (r_wave <= FULL_SCALE && r_wave >= NEG_FULL_SCALE))
        else $error("wave outside full scale");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_valid)
        else $error("finished item not shown at output");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !finish |=> $stable(r_phase))
        else $error("phase changed outside completion");

    a_crossfade_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX) |-> (r_waveform == WAVE_CROSSFADE))
        else $error("mix step without crossfade");
`endif

endmodule

[tb/sv/multi_waveform_lfo_top_tb.sv]
// ----------------------------------------------------------------------------
// multi_waveform_lfo_top_tb
// Self-checking bench for the per-channel oscillator: a tracker class keeps
// its own phase accumulators, sine table and register copies, predicts the
// value of every accepted item and checks results in order. Directed items
// cover field extremes and each wave shape, then random phases cycle the
// registers under random idling and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_waveform_lfo_top_tb;
    import mwlfo_pkg::*;

    localparam int TBL_BITS        = 10;
    localparam int QTR_LEN         = 1 << (TBL_BITS - 2);
    localparam int IDLE_PCT        = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int NUM_PHASES      = 9;
    localparam int QUIET_PHASE     = 2;
    localparam int HOLD_PHASE      = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int TAIL_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT  = 5000;

    localparam logic [CFG_W-1:0] PPH_MAX   = 28'd137438953;
    localparam logic [CFG_W-1:0] PPH_RESET = 28'd22906492;

    // codes the block treats as plain sine
    localparam t_waveform WAVE_RSVD5 = 3'd5;
    localparam t_waveform WAVE_RSVD6 = 3'd6;
    localparam t_waveform WAVE_RSVD7 = 3'd7;
    localparam t_cfg_idx  CFG_SPARE  = 2'd3;

    typedef struct packed {
        logic [0:0]         channel;
        logic [FIELD_W-1:0] rate;
        logic [FIELD_W-1:0] depth;
        logic [FIELD_W-1:0] centre;
        logic [FIELD_W-1:0] phase_offset;
    } t_lfo_item;

    class lfo_value_tracker;
        int                        sine_tbl[0:QTR_LEN];
        logic [31:0]               phase_acc[2];
        t_waveform                 waveform;
        logic [27:0]               pph;
        logic [15:0]               mix;
        logic signed [VALUE_W-1:0] expected_values[$];
        int unsigned               mismatches;

        function new();
            longint u;
            longint u2;
            longint acc;
            longint s;
            longint poly[0:6];
            poly = '{64'sd61, -64'sd3864, 64'sd172272, -64'sd5026995,
                     64'sd85569306, -64'sd693598668, 64'sd1686629713};
            for (int r = 0; r <= QTR_LEN; r++) begin
                u   = longint'(r) <<< (32 - TBL_BITS);
                u2  = (u * u) / (64'sd1 <<< 30);
                acc = poly[0];
                for (int k = 1; k < 7; k++) begin
                    acc = poly[k] + (acc * u2) / (64'sd1 <<< 30);
                end
                s = (acc * u) / (64'sd1 <<< 30);
                if (s < 0) begin
                    s = 0;
                end
                s = (s + 16384) / 32768;
                if (s > 32768) begin
                    s = 32768;
                end
                sine_tbl[r] = int'(s);
            end
            phase_acc[0] = '0;
            phase_acc[1] = '0;
            waveform     = WAVE_SINE;
            pph          = PPH_RESET;
            mix          = '0;
            mismatches   = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_WAVEFORM:     waveform = data[2:0];
                CFG_PHASE_PER_HZ: pph      = data[27:0];
                CFG_MIX:          mix      = data[15:0];
                default: ;
            endcase
        endfunction

        // top table bits, mirrored in odd quadrants, negated in the lower half
        function int table_sine(logic [31:0] ph);
            logic [7:0] r;
            int         v;
            r = ph[29:22];
            v = ph[30] ? sine_tbl[QTR_LEN - int'(r)] : sine_tbl[r];
            return ph[31] ? -v : v;
        endfunction

        function int phase_triangle(logic [31:0] ph);
            int f;
            int v;
            f = int'(ph[29:15]);
            v = ph[30] ? 32768 - f : f;
            return ph[31] ? -v : v;
        endfunction

        function logic signed [VALUE_W-1:0] oscillator_value(t_lfo_item it);
            logic [31:0] ph;
            longint      wave;
            longint      m;
            longint      w;
            longint      depth;
            longint      total;
            ph = phase_acc[it.channel];
            case (waveform)
                WAVE_COSINE:   wave = longint'(table_sine(ph + 32'h4000_0000));
                WAVE_SQUARE:   wave = (table_sine(ph) >= 0) ? -64'sd32768 : 64'sd32768;
                WAVE_TRIANGLE: wave = longint'(phase_triangle(ph));
                WAVE_CROSSFADE: begin
                    m    = (mix > 16'd32768) ? 64'sd32768 : longint'(mix);
                    w    = longint'(table_sine(ph)) * (32768 - m)
                         + longint'(phase_triangle(ph)) * m;
                    wave = (w + (64'sd1 <<< 30) + 16384) / 32768 - 32768;
                end
                default: wave = longint'(table_sine(ph + {it.phase_offset, 16'h0000}));
            endcase
            depth = longint'(it.depth);
            total = longint'(it.centre)
                  + (depth * (wave + 32768) + 16384) / 32768 - depth;
            return total[VALUE_W-1:0];
        endfunction

        function void note_item(t_lfo_item it);
            logic [63:0] step;
            expected_values.push_back(oscillator_value(it));
            step = 64'(it.rate) * 64'(pph);
            phase_acc[it.channel] = phase_acc[it.channel] + step[47:16];
        endfunction

        function void check_value(logic signed [VALUE_W-1:0] got);
            logic signed [VALUE_W-1:0] want;
            if (expected_values.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d", $time, got);
            end else begin
                want = expected_values.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, want, got);
                end
            end
        endfunction

        function int outstanding();
            return expected_values.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    mwlfo_in_if  in_ch ();
    mwlfo_out_if out_ch ();

    multi_waveform_lfo_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    lfo_value_tracker sb = new();
    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;
    int idle_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                out_ch.ready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_value(out_ch.value);
            end
            if (in_ch.valid && in_ch.ready) begin
                sb.note_item({in_ch.channel, in_ch.rate, in_ch.depth,
                              in_ch.centre, in_ch.phase_offset});
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_lfo_item make_item(logic [0:0] ch, logic [15:0] rate,
                                            logic [15:0] depth, logic [15:0] centre,
                                            logic [15:0] poff);
        t_lfo_item it;
        it.channel      = ch;
        it.rate         = rate;
        it.depth        = depth;
        it.centre       = centre;
        it.phase_offset = poff;
        return it;
    endfunction

    // extremes show up more often than a flat draw would give
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_pph();
        case ($urandom_range(0, 3))
            0:       return PPH_MAX;
            1:       return PPH_RESET;
            2:       return CFG_W'($urandom_range(0, PPH_MAX));
            default: return CFG_W'($urandom_range(PPH_MAX / 2, PPH_MAX));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_mix();
        case ($urandom_range(0, 3))
            0:       return 28'd0;
            1:       return 28'd32768;
            2:       return 28'd65535;
            default: return CFG_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_item(t_lfo_item it);
        @(negedge i_clk);
        while (!no_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.channel      = it.channel;
        in_ch.rate         = it.rate;
        in_ch.depth        = it.depth;
        in_ch.centre       = it.centre;
        in_ch.phase_offset = it.phase_offset;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // sender stops until every result is back, then the block is left to settle
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        t_waveform phase_waves[NUM_PHASES];
        phase_waves = '{WAVE_SINE, WAVE_COSINE, WAVE_SQUARE, WAVE_TRIANGLE,
                        WAVE_CROSSFADE, WAVE_RSVD5, WAVE_RSVD6, WAVE_RSVD7,
                        WAVE_CROSSFADE};
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_WAVEFORM;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.channel      = '0;
        in_ch.rate         = '0;
        in_ch.depth        = '0;
        in_ch.centre       = '0;
        in_ch.phase_offset = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings, channel 0 kept at phase zero
        send_item(make_item(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_item(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000));
        send_item(make_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_item(make_item(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h4000));
        drain();

        // square right on the zero crossing of channel 0
        write_reg(CFG_WAVEFORM, CFG_W'(WAVE_SQUARE));
        send_item(make_item(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
        send_item(make_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        drain();

        write_reg(CFG_PHASE_PER_HZ, PPH_MAX);
        write_reg(CFG_WAVEFORM, CFG_W'(WAVE_COSINE));
        send_item(make_item(1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
        send_item(make_item(1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF));
        send_item(make_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        drain();

        write_reg(CFG_WAVEFORM, CFG_W'(WAVE_TRIANGLE));
        send_item(make_item(1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
        send_item(make_item(1'b1, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0000));
        send_item(make_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        drain();

        // mix above full weight saturates
        write_reg(CFG_WAVEFORM, CFG_W'(WAVE_CROSSFADE));
        write_reg(CFG_MIX, 28'd65535);
        send_item(make_item(1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
        send_item(make_item(1'b1, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0000));
        drain();
        write_reg(CFG_MIX, 28'd16384);
        send_item(make_item(1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
        send_item(make_item(1'b1, 16'h8000, 16'hFFFF, 16'h8000, 16'h0000));
        drain();

        // unused index and an undefined shape code, frozen phase
        write_reg(CFG_SPARE, CFG_W'($urandom()));
        write_reg(CFG_WAVEFORM, CFG_W'(WAVE_RSVD7));
        write_reg(CFG_PHASE_PER_HZ, 28'd0);
        send_item(make_item(1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h4000));
        send_item(make_item(1'b1, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hC000));

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_reg(CFG_WAVEFORM, CFG_W'(phase_waves[p]));
            write_reg(CFG_PHASE_PER_HZ, pick_pph());
            write_reg(CFG_MIX, pick_mix());
            no_idle = (p == QUIET_PHASE);
            if (p == HOLD_PHASE) begin
                hold_request = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                send_item(make_item(1'($urandom_range(0, 1)), pick16(), pick16(),
                                    pick16(), pick16()));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.outstanding() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
        end
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mwlfo_pkg.sv
rtl/core/mwlfo_in_if.sv
rtl/core/mwlfo_out_if.sv
rtl/core/mwlfo_wave.sv
rtl/core/mwlfo_mac.sv
rtl/core/multi_waveform_lfo_top.sv
tb/sv/multi_waveform_lfo_top_tb.sv
